[rtl/core/gcd_lcm_unit_top_assert.svh]
// Assertion macros for the gcd/lcm unit checker.
`ifndef GCD_LCM_UNIT_TOP_ASSERT_SVH
`define GCD_LCM_UNIT_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define GLU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcd_lcm_unit_top: check failed");

// Check that cons holds in the cycle after ante.
`define GLU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcd_lcm_unit_top: check failed");

`endif

[rtl/core/glu_pkg.sv]
package glu_pkg;

  localparam int FIELD_W = 32;
  localparam int MULT_W  = 64;

  typedef struct packed {
    logic load;
    logic gcd;
    logic scale;
    logic div;
    logic mul;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic equal;
    logic k_zero;
    logic div_last;
  } stat_t;

endpackage

[rtl/core/glu_if.sv]
interface glu_op_if import glu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] operand_x;
  logic [FIELD_W-1:0] operand_y;

  modport source (output valid, output operand_x, output operand_y, input ready);
  modport sink (input valid, input operand_x, input operand_y, output ready);
endinterface

interface glu_res_if import glu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] divisor;
  logic [MULT_W-1:0]  multiple;
  logic               status;

  modport source (output valid, output divisor, output multiple, output status,
                  input ready);
  modport sink (input valid, input divisor, input multiple, input status,
                output ready);
endinterface

[rtl/core/glu_datapath.sv]
module glu_datapath import glu_pkg::*; #(
  parameter int W = 32
) (
  input  logic               clk,
  input  cmd_t               cmd,
  input  logic [FIELD_W-1:0] operand_x,
  input  logic [FIELD_W-1:0] operand_y,
  output stat_t              stat,
  output logic [FIELD_W-1:0] divisor,
  output logic [MULT_W-1:0]  multiple,
  output logic               status
);

  localparam int CW = $clog2(W);

  logic [W-1:0]   a;
  logic [W-1:0]   b;
  logic [CW-1:0]  k;
  logic           err;
  logic [W-1:0]   y_hold;
  logic [W-1:0]   rem;
  logic [W-1:0]   quo;
  logic [CW-1:0]  cnt;
  logic [2*W-1:0] prod;

  logic [W-1:0]   x_m;
  logic [W-1:0]   y_m;
  logic [W-1:0]   a_next;
  logic [W-1:0]   b_next;
  logic [CW-1:0]  k_next;
  logic [W-1:0]   diff_ab;
  logic [W-1:0]   diff_ba;
  logic [W:0]     trial;
  logic [W:0]     trial_sub;
  logic           trial_ge;

  assign x_m = operand_x[W-1:0];
  assign y_m = operand_y[W-1:0];

  // binary gcd step: strip common twos, strip lone twos, subtract odds
  always_comb begin
    a_next  = a;
    b_next  = b;
    k_next  = k;
    diff_ab = a - b;
    diff_ba = b - a;
    if (!a[0] && !b[0]) begin
      a_next = a >> 1;
      b_next = b >> 1;
      k_next = k + CW'(1);
    end else if (!a[0]) begin
      a_next = a >> 1;
    end else if (!b[0]) begin
      b_next = b >> 1;
    end else if (a > b) begin
      a_next = diff_ab >> 1;
    end else begin
      b_next = diff_ba >> 1;
    end
  end

  // restoring division of x by the gcd, one quotient bit per cycle
  always_comb begin
    trial     = {rem, quo[W-1]};
    trial_sub = trial - {1'b0, a};
    trial_ge  = (trial >= {1'b0, a});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a      <= x_m;
      b      <= y_m;
      k      <= '0;
      err    <= (x_m == '0) || (y_m == '0);
      y_hold <= y_m;
      rem    <= '0;
      quo    <= x_m;
      cnt    <= CW'(W - 1);
    end else if (cmd.gcd) begin
      a <= a_next;
      b <= b_next;
      k <= k_next;
    end else if (cmd.scale) begin
      a <= a << 1;
      k <= k - CW'(1);
    end else if (cmd.div) begin
      rem <= trial_ge ? trial_sub[W-1:0] : trial[W-1:0];
      quo <= {quo[W-2:0], trial_ge};
      cnt <= cnt - CW'(1);
    end else if (cmd.mul) begin
      prod <= {{W{1'b0}}, quo} * {{W{1'b0}}, y_hold};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      divisor  <= err ? '0 : FIELD_W'(a);
      multiple <= err ? '0 : MULT_W'(prod);
      status   <= err;
    end
  end

  assign stat.err      = err;
  assign stat.equal    = (a == b);
  assign stat.k_zero   = (k == '0);
  assign stat.div_last = (cnt == '0);

endmodule

[rtl/core/glu_ctrl.sv]
module glu_ctrl import glu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_GCD   = 6'b000010,
    ST_SCALE = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_HOLD  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_GCD;
        end
      end
      ST_GCD: begin
        if (stat.err) begin
          state_next = ST_HOLD;
        end else if (stat.equal) begin
          state_next = ST_SCALE;
        end else begin
          cmd.gcd = 1'b1;
        end
      end
      ST_SCALE: begin
        if (stat.k_zero) begin
          state_next = ST_DIV;
        end else begin
          cmd.scale = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (stat.div_last) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid || out_ready) begin
          cmd.publish    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/core/gcd_lcm_unit_top.sv]
// GCD and LCM unit.
// The operands channel carries two unsigned operands; only the low
// OPERAND_WIDTH bits of each are used. The results channel returns one
// transfer per operand transfer: the greatest common divisor, the least
// common multiple at twice the operand width, and a status bit that is set,
// with both results zero, when either operand is zero.
// One pair is worked at a time. The gcd is found by a binary gcd loop of
// one shift or subtract per cycle, then the common power of two is restored
// one bit per cycle, x is divided by the gcd one quotient bit per cycle and
// the quotient is multiplied by y. A pair with a zero operand skips these
// steps and goes straight to the result.
// The result sits in an output register, so the next operand transfer is
// taken while a result waits; a stalled receiver holds the block only once
// the next result is ready to be published.
// Reset clears the controller and drops any pending result.
module gcd_lcm_unit_top import glu_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  glu_op_if.sink    operands,
  glu_res_if.source results
);

  cmd_t               cmd;
  stat_t              stat;
  logic               out_valid;
  logic               in_ready;
  logic [FIELD_W-1:0] divisor;
  logic [MULT_W-1:0]  multiple;
  logic               status;

  glu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (results.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  glu_datapath #(
    .W (OPERAND_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .cmd       (cmd),
    .operand_x (operands.operand_x),
    .operand_y (operands.operand_y),
    .stat      (stat),
    .divisor   (divisor),
    .multiple  (multiple),
    .status    (status)
  );

  assign operands.ready   = in_ready;
  assign results.valid    = out_valid;
  assign results.divisor  = divisor;
  assign results.multiple = multiple;
  assign results.status   = status;

endmodule

[rtl/core/glu_checker.sv]
`include "gcd_lcm_unit_top_assert.svh"

module glu_checker import glu_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic [FIELD_W-1:0] res_divisor,
  input logic [MULT_W-1:0]  res_multiple,
  input logic               res_status
);

  `GLU_ASSERT_NEXT(a_valid_holds, res_valid && !res_ready, res_valid)
  `GLU_ASSERT_NOW(a_no_result_after_reset, $past(rst), !res_valid)
  `GLU_ASSERT_NOW(a_error_zero, res_valid && res_status, (res_divisor == '0) && (res_multiple == '0))
  `GLU_ASSERT_NOW(a_ok_divisor, res_valid && !res_status, res_divisor != '0)
  `GLU_ASSERT_NOW(a_ok_multiple, res_valid && !res_status, res_multiple != '0)

endmodule

bind gcd_lcm_unit_top glu_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (results.valid),
  .res_ready    (results.ready),
  .res_divisor  (results.divisor),
  .res_multiple (results.multiple),
  .res_status   (results.status)
);
